// File: design/npo_pkg.sv
// Shared constants and types for the nearest path ordering block.
package npo_pkg;

   localparam int MAX_PATHS  = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_PATHS);
   localparam int CNT_W      = $clog2(MAX_PATHS + 1);
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int DIST_W     = SQ_W + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      logic      open_flag;
   } entry_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             rev;
      coord_type        tx;
      coord_type        ty;
      coord_type        nx;
      coord_type        ny;
   } cand_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
      logic             rev;
      coord_type        nx;
      coord_type        ny;
   } best_type;

endpackage

// File: design/npo_store.sv
// Path endpoint memory: one write port, one registered read port.
module npo_store (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [npo_pkg::IDX_W-1:0] wr_addr,
   input  npo_pkg::entry_type       wr_data,
   input  logic [npo_pkg::IDX_W-1:0] rd_addr,
   output npo_pkg::entry_type       rd_data
);
   import npo_pkg::*;

   entry_type mem [MAX_PATHS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/npo_near.sv
// Pipelined squared-distance unit with nearest-candidate tracking.
module npo_near (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  npo_pkg::coord_type pen_x,
   input  npo_pkg::coord_type pen_y,
   input  npo_pkg::cand_type  feed,
   output npo_pkg::best_type  best,
   output logic               pipe_busy
);
   import npo_pkg::*;

   logic                  s1_valid_ff;
   logic [IDX_W-1:0]      s1_idx_ff;
   logic                  s1_rev_ff;
   coord_type             s1_nx_ff, s1_ny_ff;
   logic [COORD_BITS-1:0] s1_dx_ff, s1_dy_ff;

   logic                  s2_valid_ff;
   logic [IDX_W-1:0]      s2_idx_ff;
   logic                  s2_rev_ff;
   coord_type             s2_nx_ff, s2_ny_ff;
   logic [SQ_W-1:0]       s2_sqx_ff, s2_sqy_ff;

   best_type              best_ff;
   logic [DIST_W-1:0]     best_dist_ff;

   logic signed [COORD_BITS:0] diff_x, diff_y;
   logic [COORD_BITS:0]        mag_x, mag_y;
   logic [DIST_W-1:0]          sum;
   logic                       take;

   always_comb begin
      diff_x = {pen_x[COORD_BITS-1], pen_x} - {feed.tx[COORD_BITS-1], feed.tx};
      diff_y = {pen_y[COORD_BITS-1], pen_y} - {feed.ty[COORD_BITS-1], feed.ty};
      mag_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
      mag_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
      sum    = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
      take   = s2_valid_ff && (!best_ff.found || (sum < best_dist_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         best_ff.found <= 1'b0;
      end else begin
         s1_valid_ff <= feed.valid;
         s2_valid_ff <= s1_valid_ff;
         if (clear) begin
            best_ff.found <= 1'b0;
         end else if (take) begin
            best_ff.found <= 1'b1;
         end
      end
      s1_idx_ff    <= feed.idx;
      s1_rev_ff    <= feed.rev;
      s1_nx_ff     <= feed.nx;
      s1_ny_ff     <= feed.ny;
      s1_dx_ff     <= mag_x[COORD_BITS-1:0];
      s1_dy_ff     <= mag_y[COORD_BITS-1:0];
      s2_idx_ff    <= s1_idx_ff;
      s2_rev_ff    <= s1_rev_ff;
      s2_nx_ff     <= s1_nx_ff;
      s2_ny_ff     <= s1_ny_ff;
      s2_sqx_ff    <= SQ_W'(s1_dx_ff) * SQ_W'(s1_dx_ff);
      s2_sqy_ff    <= SQ_W'(s1_dy_ff) * SQ_W'(s1_dy_ff);
      if (take) begin
         best_ff.idx  <= s2_idx_ff;
         best_ff.rev  <= s2_rev_ff;
         best_ff.nx   <= s2_nx_ff;
         best_ff.ny   <= s2_ny_ff;
         best_dist_ff <= sum;
      end
   end

   assign best      = best_ff;
   assign pipe_busy = s1_valid_ff || s2_valid_ff;

endmodule

// File: design/nearest_path_order_reversible_top.sv
// Top level: batch loader, scan sequencer and result output for path ordering.
//
// Usage: load one batch of paths, one item per accepted cycle (start high,
// busy low). Each item carries the two endpoints of a path and its open flag;
// up to 64 are stored in load order, further ones are dropped. The item with
// req_last_element set ends the batch, and busy rises while the block orders
// the stored paths by greedy nearest neighbor from the origin.
// Each result (load index, reverse flag, last flag) is shown for one cycle with
// rsp_valid high; the receiver cannot stall and must take it then.
// After the last item a setup state starts the scan. For each result the
// block feeds every stored path endpoint, one distance each, through the
// shared two-stage squared distance unit, drains it, then emits the nearest.
// An empty batch gives no result and busy stays low.
// Reset clears the stored count, the used flags and the pen position; the
// endpoint memory is not cleared. After the last result the block is idle and
// ready for the next batch.
module nearest_path_order_reversible_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [15:0]            req_start_x,
   input  logic signed [15:0]            req_start_y,
   input  logic signed [15:0]            req_end_x,
   input  logic signed [15:0]            req_end_y,
   input  logic                          req_is_open,
   input  logic                          req_last_element,
   output logic                          rsp_valid,
   output logic [5:0]                    rsp_element_index,
   output logic                          rsp_reversed,
   output logic                          rsp_last_result
);
   import npo_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     emit_cnt_ff, emit_cnt_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic                 phase_ff, phase_in;
   logic [MAX_PATHS-1:0] used_ff, used_in;
   coord_type            pen_x_ff, pen_x_in;
   coord_type            pen_y_ff, pen_y_in;

   logic                 wr_en;
   entry_type            wr_data;
   logic [IDX_W-1:0]     rd_addr;
   entry_type            rd_data;
   cand_type             feed;
   best_type             best;
   logic                 pipe_busy;
   logic                 clear;
   logic                 last_out;

   npo_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   npo_near u_near (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .pen_x     (pen_x_ff),
      .pen_y     (pen_y_ff),
      .feed      (feed),
      .best      (best),
      .pipe_busy (pipe_busy)
   );

   assign wr_data = '{sx: req_start_x, sy: req_start_y, ex: req_end_x, ey: req_end_y,
                      open_flag: req_is_open};
   assign rd_addr = (state_ff != ST_SCAN) ? '0 :
                    phase_ff ? scan_ff + IDX_W'(1) : scan_ff;
   assign last_out = (emit_cnt_ff + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      emit_cnt_in = emit_cnt_ff;
      scan_in     = scan_ff;
      phase_in    = phase_ff;
      used_in     = used_ff;
      pen_x_in    = pen_x_ff;
      pen_y_in    = pen_y_ff;
      wr_en       = 1'b0;
      clear       = 1'b0;
      feed        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (count_ff < CNT_W'(MAX_PATHS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_last_element && count_in != '0) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            scan_in  = '0;
            phase_in = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            feed.idx = scan_ff;
            feed.rev = phase_ff;
            if (!phase_ff) begin
               feed.valid = !used_ff[scan_ff];
               feed.tx    = rd_data.sx;
               feed.ty    = rd_data.sy;
               feed.nx    = rd_data.open_flag ? rd_data.ex : rd_data.sx;
               feed.ny    = rd_data.open_flag ? rd_data.ey : rd_data.sy;
            end else begin
               feed.valid = !used_ff[scan_ff] && rd_data.open_flag;
               feed.tx    = rd_data.ex;
               feed.ty    = rd_data.ey;
               feed.nx    = rd_data.sx;
               feed.ny    = rd_data.sy;
            end
            phase_in = !phase_ff;
            if (phase_ff) begin
               if ({1'b0, scan_ff} == count_ff - CNT_W'(1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  scan_in = scan_ff + IDX_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            clear = 1'b1;
            if (last_out) begin
               count_in    = '0;
               emit_cnt_in = '0;
               used_in     = '0;
               pen_x_in    = '0;
               pen_y_in    = '0;
               state_in    = ST_IDLE;
            end else begin
               used_in[best.idx] = 1'b1;
               emit_cnt_in       = emit_cnt_ff + CNT_W'(1);
               pen_x_in          = best.nx;
               pen_y_in          = best.ny;
               scan_in           = '0;
               phase_in          = 1'b0;
               state_in          = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         emit_cnt_ff <= '0;
         scan_ff     <= '0;
         phase_ff    <= 1'b0;
         used_ff     <= '0;
         pen_x_ff    <= '0;
         pen_y_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         emit_cnt_ff <= emit_cnt_in;
         scan_ff     <= scan_in;
         phase_ff    <= phase_in;
         used_ff     <= used_in;
         pen_x_ff    <= pen_x_in;
         pen_y_ff    <= pen_y_in;
      end
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_valid         = state_ff == ST_EMIT;
   assign rsp_element_index = 6'(best.idx);
   assign rsp_reversed      = best.rev;
   assign rsp_last_result   = last_out;

   a_emit_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> best.found && ({1'b0, best.idx} < count_ff))
      else $error("result without a nearest candidate");

   a_emit_unused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !used_ff[best.idx])
      else $error("path emitted twice");

   a_emit_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in adjacent cycles");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |=> !busy && count_ff == '0 && used_ff == '0)
      else $error("batch state not cleared after last result");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !busy |-> used_ff == '0 && !pipe_busy)
      else $error("stale scan state while idle");

endmodule

// File: sim/nearest_path_order_reversible_top_tb.sv
// Testbench for the nearest path ordering block: loads path batches and checks the draw order.
`timescale 1ns / 1ps

module nearest_path_order_reversible_top_tb;
   import npo_pkg::*;

   typedef struct {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      logic      is_open;
      logic      last;
      int        gap;
   } path_item_type;

   typedef struct {
      logic [IDX_W-1:0] idx;
      logic             rev;
      logic             last;
   } draw_step_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   coord_type        req_start_x = '0;
   coord_type        req_start_y = '0;
   coord_type        req_end_x = '0;
   coord_type        req_end_y = '0;
   logic             req_is_open = 1'b0;
   logic             req_last_element = 1'b0;
   logic             rsp_valid;
   logic [5:0]       rsp_element_index;
   logic             rsp_reversed;
   logic             rsp_last_result;

   path_item_type    path_q[$];
   draw_step_type    draw_q[$];
   path_item_type    cur_path;
   bit               have_path = 0;
   int               hold_cnt = 0;
   int               error_count = 0;
   int               items_added = 0;
   int               gap_max = 3;

   entry_type        path_mem[MAX_PATHS];
   int               path_count = 0;

   nearest_path_order_reversible_top u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_is_open       (req_is_open),
      .req_last_element  (req_last_element),
      .rsp_valid         (rsp_valid),
      .rsp_element_index (rsp_element_index),
      .rsp_reversed      (rsp_reversed),
      .rsp_last_result   (rsp_last_result)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint sq_dist(coord_type ax, coord_type ay, coord_type bx,
                                      coord_type by);
      longint dx;
      longint dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return dx * dx + dy * dy;
   endfunction

   function automatic void order_batch();
      bit            taken[MAX_PATHS];
      coord_type     px;
      coord_type     py;
      int            best;
      bit            rev;
      bit            found;
      longint        best_d;
      longint        d;
      draw_step_type s;
      for (int i = 0; i < MAX_PATHS; i++) taken[i] = 0;
      px = '0;
      py = '0;
      for (int k = 0; k < path_count; k++) begin
         found = 0;
         best = 0;
         rev = 0;
         best_d = 0;
         for (int i = 0; i < path_count; i++) begin
            if (taken[i]) continue;
            d = sq_dist(px, py, path_mem[i].sx, path_mem[i].sy);
            if (!found || d < best_d) begin
               found = 1;
               best = i;
               rev = 0;
               best_d = d;
            end
            if (path_mem[i].open_flag) begin
               d = sq_dist(px, py, path_mem[i].ex, path_mem[i].ey);
               if (d < best_d) begin
                  best = i;
                  rev = 1;
                  best_d = d;
               end
            end
         end
         taken[best] = 1;
         if (path_mem[best].open_flag && !rev) begin
            px = path_mem[best].ex;
            py = path_mem[best].ey;
         end else begin
            px = path_mem[best].sx;
            py = path_mem[best].sy;
         end
         s.idx = best[IDX_W-1:0];
         s.rev = rev;
         s.last = (k + 1 == path_count);
         draw_q.insert(draw_q.size(), s);
      end
      path_count = 0;
   endfunction

   function automatic void load_path(path_item_type it);
      if (path_count < MAX_PATHS) begin
         path_mem[path_count].sx = it.sx;
         path_mem[path_count].sy = it.sy;
         path_mem[path_count].ex = it.ex;
         path_mem[path_count].ey = it.ey;
         path_mem[path_count].open_flag = it.is_open;
         path_count++;
      end
      if (it.last) order_batch();
   endfunction

   function automatic void queue_path(int sx, int sy, int ex, int ey, bit is_open, bit last);
      path_item_type it;
      it.sx = coord_type'(sx);
      it.sy = coord_type'(sy);
      it.ex = coord_type'(ex);
      it.ey = coord_type'(ey);
      it.is_open = is_open;
      it.last = last;
      it.gap = $urandom_range(0, gap_max);
      path_q.insert(path_q.size(), it);
      items_added++;
   endfunction

   function automatic int pick_coord();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v = int'(coord_type'($urandom));
         5, 6, 7: v = int'($urandom_range(0, 16)) - 8;
         default: begin
            case ($urandom_range(0, 3))
               0: v = -32768;
               1: v = 32767;
               2: v = -1;
               default: v = 0;
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic void queue_batch(int n);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
      for (int i = 0; i < n; i++) begin
         queue_path(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    $urandom_range(0, 1), i == n - 1);
      end
   endfunction

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // driver: wait the item's gap, then hold start until accepted
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         have_path = 0;
         hold_cnt = 0;
      end else begin
         if (start && !busy) begin
            load_path(cur_path);
            have_path = 0;
         end
         if (!(start && busy)) begin
            if (!have_path && path_q.size() > 0) begin
               cur_path = path_q.pop_front();
               have_path = 1;
               hold_cnt = cur_path.gap;
            end
            if (have_path && hold_cnt == 0) begin
               req_start_x <= cur_path.sx;
               req_start_y <= cur_path.sy;
               req_end_x <= cur_path.ex;
               req_end_y <= cur_path.ey;
               req_is_open <= cur_path.is_open;
               req_last_element <= cur_path.last;
               start <= 1'b1;
            end else begin
               if (have_path) hold_cnt--;
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      draw_step_type s;
      if (!reset && rsp_valid === 1'b1) begin
         if (draw_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual idx=%0d rev=%0d last=%0d",
                     $time, rsp_element_index, rsp_reversed, rsp_last_result);
            error_count++;
         end else begin
            s = draw_q.pop_front();
            check_field("element_index", s.idx, rsp_element_index);
            check_field("reversed", s.rev, rsp_reversed);
            check_field("last_result", s.last, rsp_last_result);
         end
      end
   end

   initial begin
      int batch_no;
      int n;
      // single closed contour at the corner, end fields ignored
      queue_path(32767, -32768, -1, -1, 0, 1);
      // open path whose end is nearer the origin is drawn reversed
      queue_path(1000, -1000, 1, 0, 1, 1);
      // equal distance at both ends: forward wins
      queue_path(3, 4, -4, -3, 1, 1);
      // index tie, then a reverse that only equals an earlier candidate
      queue_path(5, 0, 9, 9, 0, 0);
      queue_path(0, 5, 0, 0, 0, 0);
      queue_path(-9, 0, 0, -5, 1, 0);
      queue_path(-32768, -32768, 32767, 32767, 1, 1);
      // largest distances
      queue_path(-32768, -32768, 0, 0, 0, 0);
      queue_path(32767, 32767, 0, 0, 0, 0);
      queue_path(32767, -32768, -32768, 32767, 1, 0);
      queue_path(-1, -1, -21846, 21845, 1, 1);
      // coincident endpoints and duplicate paths
      queue_path(0, 0, 32767, -32768, 0, 0);
      queue_path(7, 7, 7, 7, 1, 0);
      queue_path(7, 7, 7, 7, 1, 0);
      queue_path(-2, 2, 2, -2, 1, 1);

      batch_no = 0;
      while (items_added < 410) begin
         case (batch_no)
            5: n = MAX_PATHS;
            15: n = MAX_PATHS + 2;
            25: n = MAX_PATHS + 6;
            default: n = $urandom_range(1, 8);
         endcase
         queue_batch(n);
         batch_no++;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (path_q.size() > 0 || have_path || start) @(posedge clock);
      while (draw_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
